[hw/rtl/cvd_pkg.sv]
// shared types, codes and constants for the cloth distance-constraint block
package cvd_pkg;

   localparam int unsigned IDX_W  = 10;
   localparam int unsigned SUM_W  = 66;
   localparam int unsigned ROOT_W = 35;
   localparam int unsigned QUO_W  = 17;
   localparam logic [16:0] DAMP_KEEP = 17'd64881;
   localparam logic [16:0] TENSILE_RESET = 17'd65536;

   typedef enum logic [1:0] {
      OP_LOAD      = 2'd0,
      OP_INTEGRATE = 2'd1,
      OP_RELAX     = 2'd2,
      OP_READ      = 2'd3
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_WRAP,
      ST_LOAD,
      ST_RD_A,
      ST_LAT_A,
      ST_LAT_B,
      ST_INT_MUL,
      ST_INT_ADD,
      ST_INT_UPD,
      ST_SQ_MUL,
      ST_SQ_ACC,
      ST_SQRT_GO,
      ST_SQRT_WAIT,
      ST_DIV_INIT,
      ST_DIV,
      ST_MUL_G,
      ST_MUL_C,
      ST_REL_UPD,
      ST_WR_A,
      ST_WR_B,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] prev;
      logic             pinned;
   } vertex_type;

   function automatic logic [31:0] sat32(input logic signed [39:0] v);
      logic [31:0] r;
      if (v > 40'sh007FFFFFFF) begin
         r = 32'h7FFFFFFF;
      end else if (v < -40'sh0080000000) begin
         r = 32'h80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

[hw/rtl/cvd_ram.sv]
// generic single-write, single-read synchronous ram with registered read
module cvd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/cvd_isqrt.sv]
// iterative integer square root, two radicand bits per cycle
module cvd_isqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [cvd_pkg::SUM_W-1:0]    value,
   output logic                         done,
   output logic [cvd_pkg::ROOT_W-1:0]   root
);

   localparam int unsigned SH_W  = 2 * cvd_pkg::ROOT_W;
   localparam int unsigned REM_W = cvd_pkg::ROOT_W + 3;
   localparam int unsigned CNT_W = $clog2(cvd_pkg::ROOT_W);

   logic                        run_ff, run_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [SH_W-1:0]             sh_ff, sh_in;
   logic [REM_W-1:0]            rem_ff, rem_in;
   logic [cvd_pkg::ROOT_W-1:0]  root_ff, root_in;
   logic [REM_W-1:0]            rem_next;
   logic [REM_W-1:0]            trial;

   assign rem_next = {rem_ff[REM_W-3:0], sh_ff[SH_W-1 -: 2]};
   assign trial    = REM_W'({root_ff, 2'b01});

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         sh_in   = SH_W'(value);
         rem_in  = '0;
         root_in = '0;
      end else if (run_ff) begin
         sh_in = {sh_ff[SH_W-3:0], 2'b00};
         if (rem_next >= trial) begin
            rem_in  = rem_next - trial;
            root_in = {root_ff[cvd_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_next;
            root_in = {root_ff[cvd_pkg::ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(cvd_pkg::ROOT_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      sh_ff   <= sh_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

[hw/rtl/cloth_verlet_distance_constraint.sv]
// top level: cloth vertex store with verlet integration and link relaxation
//
// one command transaction at a time: start is taken at a rising edge where busy
// is low; busy stays high until the result is on the rsp_ ports. each command
// gives exactly one result, held for one cycle and marked by rsp_strobe; the
// receiver cannot stall, so the result must be taken in that cycle. the next
// start may be taken in the same cycle the result is shown.
// relax runs the square root and three quotients, one per axis, on one
// square-root unit and one divider, both sequential, plus two vertex reads
// through the one read port of the vertex ram. an index at or above
// VERTEX_COUNT is wrapped by repeated subtraction before the vertex access.
// tensile strength is written through csr_wr_en/csr_wr_data; it is to be
// written only while idle, which the user must keep; the block does not
// enforce it. reset (synchronous, active high) returns the controller to idle
// and the strength to 1.0; the vertex ram holds no defined content until loaded.
module cloth_verlet_distance_constraint #(
   parameter int unsigned VERTEX_COUNT = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_operation,
   input  logic [9:0]         req_vertex_index,
   input  logic [9:0]         req_other_index,
   input  logic signed [31:0] req_value_x,
   input  logic signed [31:0] req_value_y,
   input  logic signed [31:0] req_value_z,
   input  logic               req_pin_flag,
   input  logic [30:0]        req_rest_length,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic               rsp_out_pinned,
   output logic               rsp_link_skipped,
   input  logic               csr_wr_en,
   input  logic [16:0]        csr_wr_data
);

   localparam int unsigned AW = $clog2(VERTEX_COUNT);
   localparam int unsigned VW = $bits(cvd_pkg::vertex_type);
   localparam logic [16:0] VC17 = 17'(VERTEX_COUNT);

   cvd_pkg::state_type   state_ff, state_in;
   cvd_pkg::op_type      op_ff, op_in;
   logic [9:0]           ia_ff, ia_in, ib_ff, ib_in;
   logic [2:0][31:0]     val_ff, val_in;
   logic                 pin_ff, pin_in;
   logic [30:0]          rest_ff, rest_in;
   logic [16:0]          tensile_ff;
   cvd_pkg::vertex_type  va_ff, va_in, vb_ff, vb_in;
   logic [1:0]           axis_ff, axis_in;
   logic [34:0]          dmp_ff, dmp_in;
   logic [2:0][31:0]     nv_ff, nv_in;
   logic [2:0][32:0]     d_ff, d_in;
   logic [65:0]          sq_ff, sq_in;
   logic [65:0]          acc_ff, acc_in;
   logic [35:0]          div_rem_ff, div_rem_in;
   logic [16:0]          div_q_ff, div_q_in;
   logic [16:0]          div_sh_ff, div_sh_in;
   logic [4:0]           div_cnt_ff, div_cnt_in;
   logic [37:0]          g_ff, g_in;
   logic [2:0][38:0]     c_ff, c_in;
   logic                 skip_ff, skip_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [2:0][31:0]     rsp_pos_ff, rsp_pos_in;
   logic                 rsp_pin_ff, rsp_pin_in;
   logic                 rsp_skip_ff, rsp_skip_in;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   cvd_pkg::vertex_type  wr_data;
   logic [AW-1:0]        rd_addr;
   logic [VW-1:0]        rd_data;
   logic [AW-1:0]        addr_a, addr_b;
   logic                 sqrt_start, sqrt_done;
   logic [34:0]          root;

   logic signed [32:0]   int_v;
   logic signed [50:0]   int_prod;
   logic signed [39:0]   int_sum;
   logic signed [32:0]   sq_d;
   logic [32:0]          sq_mag;
   logic signed [32:0]   d_cur;
   logic [32:0]          d_mag;
   logic [35:0]          div_trial;
   logic [35:0]          div_len;
   logic signed [17:0]   f_mag, f_val;
   logic signed [35:0]   rel_diff;
   logic signed [53:0]   g_prod;
   logic signed [55:0]   c_prod;

   assign addr_a = AW'(ia_ff);
   assign addr_b = AW'(ib_ff);

   cvd_ram #(
      .WIDTH (VW),
      .DEPTH (VERTEX_COUNT)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cvd_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (acc_ff),
      .done  (sqrt_done),
      .root  (root)
   );

   // per-axis datapath terms
   assign int_v    = 33'($signed(va_ff.pos[axis_ff])) - 33'($signed(va_ff.prev[axis_ff]));
   assign int_prod = int_v * $signed({1'b0, cvd_pkg::DAMP_KEEP});
   assign int_sum  = 40'($signed(va_ff.pos[axis_ff])) + 40'($signed(dmp_ff))
                   + 40'($signed(val_ff[axis_ff]));
   assign sq_d     = 33'($signed(vb_ff.pos[axis_ff])) - 33'($signed(va_ff.pos[axis_ff]));
   assign sq_mag   = sq_d[32] ? 33'(-sq_d) : 33'(sq_d);
   assign d_cur    = $signed(d_ff[axis_ff]);
   assign d_mag    = d_cur[32] ? 33'(-d_cur) : 33'(d_cur);
   assign div_trial = {div_rem_ff[34:0], div_sh_ff[16]};
   assign div_len  = 36'(root);
   assign f_mag    = $signed({1'b0, div_q_ff});
   assign f_val    = d_cur[32] ? -f_mag : f_mag;
   assign rel_diff = $signed(36'(root)) - $signed(36'(rest_ff));
   assign g_prod   = f_val * rel_diff;
   assign c_prod   = $signed(g_ff) * $signed({1'b0, tensile_ff});

   assign rd_addr = (state_ff == cvd_pkg::ST_LAT_A) ? addr_b : addr_a;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      ia_in         = ia_ff;
      ib_in         = ib_ff;
      val_in        = val_ff;
      pin_in        = pin_ff;
      rest_in       = rest_ff;
      va_in         = va_ff;
      vb_in         = vb_ff;
      axis_in       = axis_ff;
      dmp_in        = dmp_ff;
      nv_in         = nv_ff;
      d_in          = d_ff;
      sq_in         = sq_ff;
      acc_in        = acc_ff;
      div_rem_in    = div_rem_ff;
      div_q_in      = div_q_ff;
      div_sh_in     = div_sh_ff;
      div_cnt_in    = div_cnt_ff;
      g_in          = g_ff;
      c_in          = c_ff;
      skip_in       = skip_ff;
      rsp_strobe_in = 1'b0;
      rsp_pos_in    = rsp_pos_ff;
      rsp_pin_in    = rsp_pin_ff;
      rsp_skip_in   = rsp_skip_ff;
      wr_en         = 1'b0;
      wr_addr       = addr_a;
      wr_data       = va_ff;
      sqrt_start    = 1'b0;

      unique case (state_ff)
         cvd_pkg::ST_IDLE: begin
            if (start) begin
               op_in     = cvd_pkg::op_type'(req_operation);
               ia_in     = req_vertex_index;
               ib_in     = req_other_index;
               val_in    = {req_value_z, req_value_y, req_value_x};
               pin_in    = req_pin_flag;
               rest_in   = req_rest_length;
               skip_in   = 1'b0;
               axis_in   = '0;
               state_in  = cvd_pkg::ST_WRAP;
            end
         end
         cvd_pkg::ST_WRAP: begin
            if (17'(ia_ff) >= VC17) begin
               ia_in = 10'(17'(ia_ff) - VC17);
            end
            if (17'(ib_ff) >= VC17) begin
               ib_in = 10'(17'(ib_ff) - VC17);
            end
            if (17'(ia_ff) < VC17 && 17'(ib_ff) < VC17) begin
               state_in = (op_ff == cvd_pkg::OP_LOAD) ? cvd_pkg::ST_LOAD : cvd_pkg::ST_RD_A;
            end
         end
         cvd_pkg::ST_LOAD: begin
            va_in.pos    = val_ff;
            va_in.prev   = val_ff;
            va_in.pinned = pin_ff;
            wr_en        = 1'b1;
            wr_data      = va_in;
            state_in     = cvd_pkg::ST_RESP;
         end
         cvd_pkg::ST_RD_A: begin
            state_in = cvd_pkg::ST_LAT_A;
         end
         cvd_pkg::ST_LAT_A: begin
            va_in = cvd_pkg::vertex_type'(rd_data);
            priority case (op_ff)
               cvd_pkg::OP_INTEGRATE: state_in = cvd_pkg::ST_INT_MUL;
               cvd_pkg::OP_RELAX:     state_in = cvd_pkg::ST_LAT_B;
               default:               state_in = cvd_pkg::ST_RESP;
            endcase
         end
         cvd_pkg::ST_LAT_B: begin
            vb_in    = cvd_pkg::vertex_type'(rd_data);
            acc_in   = '0;
            state_in = cvd_pkg::ST_SQ_MUL;
         end
         cvd_pkg::ST_INT_MUL: begin
            dmp_in   = int_prod[50:16];
            state_in = cvd_pkg::ST_INT_ADD;
         end
         cvd_pkg::ST_INT_ADD: begin
            nv_in[axis_ff] = cvd_pkg::sat32(int_sum);
            if (axis_ff == 2'd2) begin
               axis_in  = '0;
               state_in = cvd_pkg::ST_INT_UPD;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = cvd_pkg::ST_INT_MUL;
            end
         end
         cvd_pkg::ST_INT_UPD: begin
            if (!va_ff.pinned) begin
               va_in.prev   = va_ff.pos;
               va_in.pos[0] = nv_ff[0];
               va_in.pos[1] = nv_ff[1][31] ? va_ff.pos[1] : nv_ff[1];
               va_in.pos[2] = nv_ff[2];
            end
            state_in = cvd_pkg::ST_WR_A;
         end
         cvd_pkg::ST_SQ_MUL: begin
            d_in[axis_ff] = sq_d;
            sq_in         = sq_mag * sq_mag;
            state_in      = cvd_pkg::ST_SQ_ACC;
         end
         cvd_pkg::ST_SQ_ACC: begin
            acc_in = acc_ff + sq_ff;
            if (axis_ff == 2'd2) begin
               axis_in  = '0;
               state_in = cvd_pkg::ST_SQRT_GO;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = cvd_pkg::ST_SQ_MUL;
            end
         end
         cvd_pkg::ST_SQRT_GO: begin
            sqrt_start = 1'b1;
            state_in   = cvd_pkg::ST_SQRT_WAIT;
         end
         cvd_pkg::ST_SQRT_WAIT: begin
            if (sqrt_done) begin
               if (root == '0) begin
                  skip_in  = 1'b1;
                  state_in = cvd_pkg::ST_RESP;
               end else begin
                  state_in = cvd_pkg::ST_DIV_INIT;
               end
            end
         end
         cvd_pkg::ST_DIV_INIT: begin
            div_rem_in = 36'(d_mag[32:1]);
            div_sh_in  = {d_mag[0], 16'd0};
            div_q_in   = '0;
            div_cnt_in = '0;
            state_in   = cvd_pkg::ST_DIV;
         end
         cvd_pkg::ST_DIV: begin
            if (div_trial >= div_len) begin
               div_rem_in = div_trial - div_len;
               div_q_in   = {div_q_ff[15:0], 1'b1};
            end else begin
               div_rem_in = div_trial;
               div_q_in   = {div_q_ff[15:0], 1'b0};
            end
            div_sh_in  = {div_sh_ff[15:0], 1'b0};
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == 5'(cvd_pkg::QUO_W - 1)) begin
               state_in = cvd_pkg::ST_MUL_G;
            end
         end
         cvd_pkg::ST_MUL_G: begin
            g_in     = g_prod[53:16];
            state_in = cvd_pkg::ST_MUL_C;
         end
         cvd_pkg::ST_MUL_C: begin
            c_in[axis_ff] = c_prod[55:17];
            if (axis_ff == 2'd2) begin
               axis_in  = '0;
               state_in = cvd_pkg::ST_REL_UPD;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = cvd_pkg::ST_DIV_INIT;
            end
         end
         cvd_pkg::ST_REL_UPD: begin
            for (int k = 0; k < 3; k++) begin
               if (!va_ff.pinned) begin
                  va_in.pos[k] = cvd_pkg::sat32(40'($signed(va_ff.pos[k]))
                                              + 40'($signed(c_ff[k])));
               end
               if (!vb_ff.pinned) begin
                  vb_in.pos[k] = cvd_pkg::sat32(40'($signed(vb_ff.pos[k]))
                                              - 40'($signed(c_ff[k])));
               end
            end
            state_in = cvd_pkg::ST_WR_A;
         end
         cvd_pkg::ST_WR_A: begin
            wr_en    = 1'b1;
            state_in = (op_ff == cvd_pkg::OP_RELAX) ? cvd_pkg::ST_WR_B : cvd_pkg::ST_RESP;
         end
         cvd_pkg::ST_WR_B: begin
            wr_en    = 1'b1;
            wr_addr  = addr_b;
            wr_data  = vb_ff;
            state_in = cvd_pkg::ST_RESP;
         end
         cvd_pkg::ST_RESP: begin
            rsp_strobe_in = 1'b1;
            rsp_pos_in    = va_ff.pos;
            rsp_pin_in    = va_ff.pinned;
            rsp_skip_in   = skip_ff;
            state_in      = cvd_pkg::ST_IDLE;
         end
         default: begin
            state_in = cvd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cvd_pkg::ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         tensile_ff    <= cvd_pkg::TENSILE_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) begin
            tensile_ff <= csr_wr_data;
         end
      end
      op_ff      <= op_in;
      ia_ff      <= ia_in;
      ib_ff      <= ib_in;
      val_ff     <= val_in;
      pin_ff     <= pin_in;
      rest_ff    <= rest_in;
      va_ff      <= va_in;
      vb_ff      <= vb_in;
      axis_ff    <= axis_in;
      dmp_ff     <= dmp_in;
      nv_ff      <= nv_in;
      d_ff       <= d_in;
      sq_ff      <= sq_in;
      acc_ff     <= acc_in;
      div_rem_ff <= div_rem_in;
      div_q_ff   <= div_q_in;
      div_sh_ff  <= div_sh_in;
      div_cnt_ff <= div_cnt_in;
      g_ff       <= g_in;
      c_ff       <= c_in;
      skip_ff    <= skip_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_pin_ff <= rsp_pin_in;
      rsp_skip_ff <= rsp_skip_in;
   end

   assign busy             = (state_ff != cvd_pkg::ST_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_out_x        = $signed(rsp_pos_ff[0]);
   assign rsp_out_y        = $signed(rsp_pos_ff[1]);
   assign rsp_out_z        = $signed(rsp_pos_ff[2]);
   assign rsp_out_pinned   = rsp_pin_ff;
   assign rsp_link_skipped = rsp_skip_ff;

`ifndef SYNTHESIS
   a_strobe_after_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == cvd_pkg::ST_RESP))
      else $error("result strobe without a finishing transaction");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> state_ff == cvd_pkg::ST_WRAP)
      else $error("accepted transaction did not start");

   a_skip_only_relax: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_link_skipped |-> op_ff == cvd_pkg::OP_RELAX)
      else $error("link skip flagged outside relax");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> busy)
      else $error("vertex ram written while idle");
`endif

endmodule

[verif/tb.sv]
// self-checking testbench for the cloth verlet distance-constraint block
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NVERT = 1024;
   localparam int STALL_LIMIT = 3000;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               pinned;
      logic               skipped;
   } result_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_operation;
   logic [9:0]         req_vertex_index;
   logic [9:0]         req_other_index;
   logic signed [31:0] req_value_x;
   logic signed [31:0] req_value_y;
   logic signed [31:0] req_value_z;
   logic               req_pin_flag;
   logic [30:0]        req_rest_length;
   logic               rsp_strobe;
   logic signed [31:0] rsp_out_x;
   logic signed [31:0] rsp_out_y;
   logic signed [31:0] rsp_out_z;
   logic               rsp_out_pinned;
   logic               rsp_link_skipped;
   logic               csr_wr_en;
   logic [16:0]        csr_wr_data;

   cloth_verlet_distance_constraint dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_vertex_index(req_vertex_index),
      .req_other_index(req_other_index), .req_value_x(req_value_x),
      .req_value_y(req_value_y), .req_value_z(req_value_z),
      .req_pin_flag(req_pin_flag), .req_rest_length(req_rest_length),
      .rsp_strobe(rsp_strobe), .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y),
      .rsp_out_z(rsp_out_z), .rsp_out_pinned(rsp_out_pinned),
      .rsp_link_skipped(rsp_link_skipped), .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // predictor state
   logic signed [31:0] pos_x[NVERT], pos_y[NVERT], pos_z[NVERT];
   logic signed [31:0] old_x[NVERT], old_y[NVERT], old_z[NVERT];
   logic               pin_mem[NVERT];
   bit                 loaded[NVERT];
   int                 live_list[$];
   int                 hot_index[16];
   longint             strength;

   result_type expected_results[$];
   int  fail_count = 0;
   int  idle_cycles = 0;
   bit  no_gaps = 0;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] verlet_axis(logic signed [31:0] p,
                                                      logic signed [31:0] q, longint acc);
      longint vel, damped;
      vel = longint'(p) - longint'(q);
      damped = (vel * longint'(cvd_pkg::DAMP_KEEP)) >>> 16;
      return clamp32(longint'(p) + damped + acc);
   endfunction

   function automatic longint link_shift(longint d, longint len, longint diff);
      longint f, g;
      f = (d * 64'sd65536) / len;
      g = (f * diff) >>> 16;
      return (g * strength) >>> 17;
   endfunction

   function automatic result_type predict_step(cvd_pkg::op_type op, int a, int b,
         logic signed [31:0] vx, logic signed [31:0] vy, logic signed [31:0] vz,
         logic pin, logic [30:0] rest);
      result_type r;
      logic signed [31:0] nx, ny, nz;
      longint dx, dy, dz, len, diff, cx, cy, cz;
      logic signed [127:0] wx, wy, wz;
      logic [127:0] sq, cand;
      r.skipped = 0;
      case (op)
         cvd_pkg::OP_LOAD: begin
            pos_x[a] = vx; pos_y[a] = vy; pos_z[a] = vz;
            old_x[a] = vx; old_y[a] = vy; old_z[a] = vz;
            pin_mem[a] = pin;
         end
         cvd_pkg::OP_INTEGRATE: begin
            if (!pin_mem[a]) begin
               nx = verlet_axis(pos_x[a], old_x[a], longint'(vx));
               ny = verlet_axis(pos_y[a], old_y[a], longint'(vy));
               nz = verlet_axis(pos_z[a], old_z[a], longint'(vz));
               old_x[a] = pos_x[a]; old_y[a] = pos_y[a]; old_z[a] = pos_z[a];
               if (ny < 0) ny = pos_y[a];
               pos_x[a] = nx; pos_y[a] = ny; pos_z[a] = nz;
            end
         end
         cvd_pkg::OP_RELAX: begin
            dx = longint'(pos_x[b]) - longint'(pos_x[a]);
            dy = longint'(pos_y[b]) - longint'(pos_y[a]);
            dz = longint'(pos_z[b]) - longint'(pos_z[a]);
            wx = dx; wy = dy; wz = dz;
            sq = wx * wx + wy * wy + wz * wz;
            len = 0;
            for (int k = 34; k >= 0; k--) begin
               cand = len | (64'sd1 << k);
               if (cand * cand <= sq) len = cand;
            end
            if (len == 0) begin
               r.skipped = 1;
            end else begin
               diff = len - longint'({33'd0, rest});
               cx = link_shift(dx, len, diff);
               cy = link_shift(dy, len, diff);
               cz = link_shift(dz, len, diff);
               if (!pin_mem[a]) begin
                  pos_x[a] = clamp32(longint'(pos_x[a]) + cx);
                  pos_y[a] = clamp32(longint'(pos_y[a]) + cy);
                  pos_z[a] = clamp32(longint'(pos_z[a]) + cz);
               end
               if (!pin_mem[b]) begin
                  pos_x[b] = clamp32(longint'(pos_x[b]) - cx);
                  pos_y[b] = clamp32(longint'(pos_y[b]) - cy);
                  pos_z[b] = clamp32(longint'(pos_z[b]) - cz);
               end
            end
         end
         default: begin
         end
      endcase
      r.x = pos_x[a]; r.y = pos_y[a]; r.z = pos_z[a]; r.pinned = pin_mem[a];
      return r;
   endfunction

   // drive one transaction and wait for it to be taken
   task automatic send_command(cvd_pkg::op_type op, int a, int b, logic [31:0] vx,
         logic [31:0] vy, logic [31:0] vz, logic pin, logic [30:0] rest);
      start <= 1;
      req_operation <= op;
      req_vertex_index <= a[9:0];
      req_other_index <= b[9:0];
      req_value_x <= vx;
      req_value_y <= vy;
      req_value_z <= vz;
      req_pin_flag <= pin;
      req_rest_length <= rest;
      do @(posedge clock); while (busy);
      if (op == cvd_pkg::OP_LOAD && !loaded[a]) begin
         loaded[a] = 1;
         live_list.insert(live_list.size(), a);
      end
      expected_results.insert(expected_results.size(),
                              predict_step(op, a, b, vx, vy, vz, pin, rest));
      if (!no_gaps && $urandom_range(99) < 10) begin
         start <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic write_strength(logic [16:0] value);
      start <= 0;
      wait (expected_results.size() == 0);
      @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= value;
      @(posedge clock);
      strength = value;
      csr_wr_en <= 0;
   endtask

   // result checker
   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result x=%h", $time, rsp_out_x);
            fail_count++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_out_x !== e.x) begin
               $display("%0t: out_x exp %h act %h", $time, e.x, rsp_out_x);
               fail_count++;
            end
            if (rsp_out_y !== e.y) begin
               $display("%0t: out_y exp %h act %h", $time, e.y, rsp_out_y);
               fail_count++;
            end
            if (rsp_out_z !== e.z) begin
               $display("%0t: out_z exp %h act %h", $time, e.z, rsp_out_z);
               fail_count++;
            end
            if (rsp_out_pinned !== e.pinned) begin
               $display("%0t: out_pinned exp %b act %b", $time, e.pinned, rsp_out_pinned);
               fail_count++;
            end
            if (rsp_link_skipped !== e.skipped) begin
               $display("%0t: link_skipped exp %b act %b", $time, e.skipped,
                        rsp_link_skipped);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   function automatic logic [31:0] rand_coord();
      if ($urandom_range(99) < 85) return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
      return $urandom;
   endfunction

   function automatic logic [31:0] rand_accel();
      if ($urandom_range(99) < 80) return $urandom_range(0, 32'h8000) - 32'h4000;
      return $urandom;
   endfunction

   function automatic int pick_live();
      if ($urandom_range(99) < 80 && live_list.size() > 12)
         return live_list[$urandom_range(11)];
      return live_list[$urandom_range(live_list.size() - 1)];
   endfunction

   task automatic test_directed();
      send_command(cvd_pkg::OP_LOAD, 0, 1023, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   0, 0);
      send_command(cvd_pkg::OP_INTEGRATE, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   0, 0);
      send_command(cvd_pkg::OP_LOAD, 1023, 0, 32'h80000000, 32'h80000000, 32'h80000000,
                   1, 0);
      send_command(cvd_pkg::OP_INTEGRATE, 1023, 0, 32'h7FFFFFFF, 32'h00010000, 0, 1, 0);
      send_command(cvd_pkg::OP_READ, 1023, 512, 0, 0, 0, 0, 31'h7FFFFFFF);
      send_command(cvd_pkg::OP_RELAX, 0, 1023, 0, 0, 0, 0, 31'h7FFFFFFF);
      send_command(cvd_pkg::OP_RELAX, 0, 1023, 0, 0, 0, 0, 0);
      send_command(cvd_pkg::OP_LOAD, 5, 0, 32'h00010000, 32'h00050000, 32'hFFFF0000, 0, 0);
      send_command(cvd_pkg::OP_INTEGRATE, 5, 0, 32'h00001000, 32'hFFF00000, 32'h00000100,
                   0, 0);
      send_command(cvd_pkg::OP_INTEGRATE, 5, 0, 0, 32'hFFFFF000, 0, 0, 0);
      send_command(cvd_pkg::OP_INTEGRATE, 5, 0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                   0, 0);
      send_command(cvd_pkg::OP_LOAD, 6, 0, 32'h00010000, 32'h00050000, 32'hFFFF0000, 0, 0);
      send_command(cvd_pkg::OP_LOAD, 7, 0, 32'h00010000, 32'h00050000, 32'hFFFF0000, 0, 0);
      send_command(cvd_pkg::OP_RELAX, 6, 7, 0, 0, 0, 0, 31'h00010000);
      send_command(cvd_pkg::OP_RELAX, 6, 6, 0, 0, 0, 0, 31'h00010000);
      send_command(cvd_pkg::OP_LOAD, 8, 0, 32'h00030000, 32'h00040000, 0, 0, 0);
      send_command(cvd_pkg::OP_RELAX, 6, 8, 0, 0, 0, 0, 31'h00010000);
      send_command(cvd_pkg::OP_RELAX, 8, 0, 0, 0, 0, 0, 31'h00020000);
      send_command(cvd_pkg::OP_RELAX, 1023, 8, 0, 0, 0, 0, 0);
      send_command(cvd_pkg::OP_LOAD, 682, 341, 32'h55555555, 32'h2AAAAAAA, 32'hAAAAAAAA,
                   1, 0);
      send_command(cvd_pkg::OP_READ, 682, 0, 0, 0, 0, 0, 0);
      send_command(cvd_pkg::OP_RELAX, 682, 1023, 0, 0, 0, 0, 31'h2AAAAAAA);
   endtask

   task automatic test_random(int count);
      int a, b, k;
      cvd_pkg::op_type op;
      for (int n = 0; n < count; n++) begin
         k = $urandom_range(99);
         if (k < 20) op = cvd_pkg::OP_LOAD;
         else if (k < 50) op = cvd_pkg::OP_INTEGRATE;
         else if (k < 85) op = cvd_pkg::OP_RELAX;
         else op = cvd_pkg::OP_READ;
         if (op == cvd_pkg::OP_LOAD) begin
            a = ($urandom_range(99) < 70) ? hot_index[$urandom_range(15)] : $urandom_range(1023);
         end else begin
            a = pick_live();
         end
         b = (op == cvd_pkg::OP_RELAX) ? (($urandom_range(99) < 5) ? a : pick_live())
                                       : $urandom_range(1023);
         k = $urandom_range(99);
         send_command(op, a, b,
            (op == cvd_pkg::OP_LOAD) ? rand_coord() : rand_accel(),
            (op == cvd_pkg::OP_LOAD) ? rand_coord() : rand_accel(),
            (op == cvd_pkg::OP_LOAD) ? rand_coord() : rand_accel(),
            $urandom_range(99) < 20,
            (k < 60) ? 31'($urandom_range(0, 32'h0080_0000)) : (k < 80) ? 31'd0 : 31'($urandom));
      end
   endtask

   task automatic test_strength_settings();
      write_strength(17'd0);
      test_random(170);
      write_strength(17'h1FFFF);
      no_gaps = 1;
      test_random(170);
      no_gaps = 0;
      write_strength(cvd_pkg::TENSILE_RESET);
      test_random(170);
      write_strength(17'($urandom_range(1, 65535)));
      test_random(170);
   endtask

   initial begin
      reset <= 1;
      start <= 0;
      req_operation <= cvd_pkg::OP_READ;
      req_vertex_index <= 0;
      req_other_index <= 0;
      req_value_x <= 0;
      req_value_y <= 0;
      req_value_z <= 0;
      req_pin_flag <= 0;
      req_rest_length <= 0;
      csr_wr_en <= 0;
      csr_wr_data <= 0;
      strength = 65536;
      for (int i = 0; i < 16; i++) hot_index[i] = $urandom_range(1023);
      repeat (7) @(posedge clock);
      reset <= 0;
      test_directed();
      test_random(60);
      test_strength_settings();
      start <= 0;
      wait (expected_results.size() == 0);
      repeat (150) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
